>>> rtl/hzo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hzo_pkg
// Shared widths, types and state encodings of the hierarchical Z-order
// address decoder.
// ----------------------------------------------------------------------------
package hzo_pkg;

  localparam int NUM_AXES  = 5;
  localparam int ADDR_W    = 63;
  localparam int COORD_W   = 24;
  localparam int EXP_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int LVL_W     = 6;
  localparam int NCNT_W    = 8;
  localparam int GRP_W     = 8;
  localparam int NUM_GRP   = 8;
  localparam int GIDX_W    = 3;

  typedef logic [LVL_W-1:0] lvl_t;

  // Level count and the matching mask of the address bits that are decoded.
  typedef struct packed {
    lvl_t              level_count;
    logic [ADDR_W-1:0] low_mask;
  } lvl_info_t;

  // Aligned level bits on their way to the scatter stage.
  typedef struct packed {
    logic [ADDR_W-1:0] bits;
    logic              too_big;
  } hzo_word_t;

  typedef enum logic {
    LM_IDLE,
    LM_BUILD
  } lm_state_e;

endpackage

>>> rtl/hz_order_to_coordinates.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hz_order_to_coordinates
// Addresses pass through the five-stage pipeline, one address per cycle
// while in_stall_o is low; a level-map rebuild or out_stall_i holds it.
// After each configuration write the input is stalled while the level map
// is rebuilt, one threshold per cycle.
// Reset (asynchronous, active low) clears exponents, level map and pipeline.
// ----------------------------------------------------------------------------
module hz_order_to_coordinates #(
  parameter int MAX_LEVELS = 63,
  parameter int AXIS_COUNT = 5,
  parameter int AXIS_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hzo_pkg::ADDR_W-1:0]    hz_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hzo_pkg::COORD_W-1:0]   coord_x_o,
  output logic [hzo_pkg::COORD_W-1:0]   coord_y_o,
  output logic [hzo_pkg::COORD_W-1:0]   coord_z_o,
  output logic [hzo_pkg::COORD_W-1:0]   coord_u_o,
  output logic [hzo_pkg::COORD_W-1:0]   coord_v_o,
  output logic                          address_too_big_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hzo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hzo_pkg::EXP_W-1:0]     cfg_data_i
);

  localparam int KEEP_BITS = (AXIS_BITS < hzo_pkg::COORD_W) ? AXIS_BITS : hzo_pkg::COORD_W;

  logic                        busy;
  hzo_pkg::lvl_info_t          info;
  hzo_pkg::lvl_t               pos    [hzo_pkg::NUM_AXES][KEEP_BITS];
  logic                        pos_ok [hzo_pkg::NUM_AXES][KEEP_BITS];
  logic                        align_ready;
  logic                        align_valid;
  hzo_pkg::hzo_word_t          align_word;
  logic                        scatter_ready;
  logic [hzo_pkg::COORD_W-1:0] coord [hzo_pkg::NUM_AXES];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy || !align_ready;

  hzo_level_map #(
    .MAX_LEVELS (MAX_LEVELS),
    .AXIS_COUNT (AXIS_COUNT),
    .KEEP_BITS  (KEEP_BITS)
  ) u_level_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .info_o      (info),
    .pos_o       (pos),
    .pos_ok_o    (pos_ok)
  );

  hzo_align u_align (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i && !busy),
    .in_ready_o  (align_ready),
    .addr_i      (hz_address_i),
    .info_i      (info),
    .out_valid_o (align_valid),
    .out_ready_i (scatter_ready),
    .out_o       (align_word)
  );

  hzo_scatter #(
    .KEEP_BITS (KEEP_BITS)
  ) u_scatter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (align_valid),
    .in_ready_o  (scatter_ready),
    .word_i      (align_word),
    .pos_i       (pos),
    .pos_ok_i    (pos_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .coord_o     (coord),
    .too_big_o   (address_too_big_o)
  );

  assign coord_x_o = coord[0];
  assign coord_y_o = coord[1];
  assign coord_z_o = coord[2];
  assign coord_u_o = coord[3];
  assign coord_v_o = coord[4];

endmodule

>>> rtl/hzo_level_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hzo_level_map
// Holds the axis exponents and rebuilds, one threshold per cycle, the level
// position of every coordinate bit of every axis.
// ----------------------------------------------------------------------------
module hzo_level_map #(
  parameter int MAX_LEVELS = 63,
  parameter int AXIS_COUNT = 5,
  parameter int KEEP_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [hzo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hzo_pkg::EXP_W-1:0]     cfg_data_i,
  output logic                          busy_o,
  output hzo_pkg::lvl_info_t            info_o,
  output hzo_pkg::lvl_t                 pos_o    [hzo_pkg::NUM_AXES][KEEP_BITS],
  output logic                          pos_ok_o [hzo_pkg::NUM_AXES][KEEP_BITS]
);

  localparam int KIDX_W = (KEEP_BITS > 1) ? $clog2(KEEP_BITS) : 1;
  localparam logic [KIDX_W-1:0] K_LAST = KIDX_W'(KEEP_BITS - 1);

  logic [hzo_pkg::EXP_W-1:0]  axis_bits_q [hzo_pkg::NUM_AXES];
  logic [hzo_pkg::EXP_W-1:0]  eff_bits    [hzo_pkg::NUM_AXES];
  hzo_pkg::lm_state_e         state_q, state_d;
  logic [KIDX_W-1:0]          k_q, k_d;
  logic [hzo_pkg::NCNT_W-1:0] n_q, n_d;
  logic [hzo_pkg::NCNT_W-1:0] exp_sum;
  logic [hzo_pkg::NCNT_W-1:0] level_total;
  logic [hzo_pkg::NCNT_W-1:0] step_total;
  logic [hzo_pkg::NCNT_W-1:0] pos_full [hzo_pkg::NUM_AXES];
  logic                       ge       [hzo_pkg::NUM_AXES];
  logic [2:0]                 above    [hzo_pkg::NUM_AXES];
  logic                       build_we;
  hzo_pkg::lvl_info_t         info_q, info_d;
  hzo_pkg::lvl_t              pos_q    [hzo_pkg::NUM_AXES][KEEP_BITS];
  logic                       pos_ok_q [hzo_pkg::NUM_AXES][KEEP_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
        axis_bits_q[a] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < hzo_pkg::CFG_IDX_W'(hzo_pkg::NUM_AXES))) begin
      axis_bits_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Axes beyond the configured count behave as if their exponent were zero.
  always_comb begin
    exp_sum = '0;
    for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
      eff_bits[a] = (a < AXIS_COUNT) ? axis_bits_q[a] : '0;
      exp_sum     = exp_sum + hzo_pkg::NCNT_W'(eff_bits[a]);
    end
    level_total = (exp_sum > hzo_pkg::NCNT_W'(MAX_LEVELS)) ?
                  hzo_pkg::NCNT_W'(MAX_LEVELS) : exp_sum;
    info_d.level_count = level_total[hzo_pkg::LVL_W-1:0];
    for (int i = 0; i < hzo_pkg::ADDR_W; i++) begin
      info_d.low_mask[i] = (hzo_pkg::NCNT_W'(i) < level_total);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      info_q <= '0;
    end else begin
      info_q <= info_d;
    end
  end

  // Every write restarts the sweep, so the table always matches the latest
  // exponents once the block is idle again.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hzo_pkg::LM_IDLE: begin
        if (cfg_valid_i) state_d = hzo_pkg::LM_BUILD;
      end
      hzo_pkg::LM_BUILD: begin
        if (cfg_valid_i) begin
          state_d = hzo_pkg::LM_BUILD;
        end else if (k_q == K_LAST) begin
          state_d = hzo_pkg::LM_IDLE;
        end
      end
      default: state_d = hzo_pkg::LM_IDLE;
    endcase
  end

  always_comb begin
    busy_o   = 1'b0;
    build_we = 1'b0;
    unique case (state_q)
      hzo_pkg::LM_IDLE: begin
        busy_o   = 1'b0;
        build_we = 1'b0;
      end
      hzo_pkg::LM_BUILD: begin
        busy_o   = 1'b1;
        build_we = 1'b1;
      end
      default: begin
        busy_o   = 1'b0;
        build_we = 1'b0;
      end
    endcase
  end

  // At threshold k+1 the axes still active take consecutive levels, the
  // highest axis index first, starting after all levels of lower thresholds.
  always_comb begin
    step_total = '0;
    for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
      ge[a]      = eff_bits[a] > hzo_pkg::EXP_W'(k_q);
      step_total = step_total + hzo_pkg::NCNT_W'(ge[a]);
    end
    for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
      above[a] = '0;
      for (int b = 0; b < hzo_pkg::NUM_AXES; b++) begin
        if (b > a && ge[b]) above[a] = above[a] + 3'd1;
      end
      pos_full[a] = n_q + hzo_pkg::NCNT_W'(above[a]);
    end
    k_d = k_q;
    n_d = n_q;
    if (cfg_valid_i) begin
      k_d = '0;
      n_d = '0;
    end else if (build_we) begin
      k_d = k_q + KIDX_W'(1);
      n_d = n_q + step_total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hzo_pkg::LM_IDLE;
      k_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
        for (int k = 0; k < KEEP_BITS; k++) begin
          pos_ok_q[a][k] <= 1'b0;
        end
      end
    end else if (build_we && !cfg_valid_i) begin
      for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
        pos_ok_q[a][k_q] <= ge[a] && (pos_full[a] < hzo_pkg::NCNT_W'(MAX_LEVELS));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (build_we && !cfg_valid_i) begin
      for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
        pos_q[a][k_q] <= pos_full[a][hzo_pkg::LVL_W-1:0];
      end
    end
  end

  assign info_o   = info_q;
  assign pos_o    = pos_q;
  assign pos_ok_o = pos_ok_q;

endmodule

>>> rtl/hzo_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hzo_align
// Four-stage pipeline that masks the address, finds its leading one and
// shifts (2h+1) up until its top bit lands on the level count.
// ----------------------------------------------------------------------------
module hzo_align (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hzo_pkg::ADDR_W-1:0] addr_i,
  input  hzo_pkg::lvl_info_t         info_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hzo_pkg::hzo_word_t         out_o
);

  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1: mask and per-group leading-one search.
  logic                        s1_vld_q;
  logic [hzo_pkg::ADDR_W-1:0]  s1_hm_q;
  logic                        s1_big_q;
  logic [hzo_pkg::NUM_GRP-1:0] s1_any_q;
  logic [hzo_pkg::GIDX_W-1:0]  s1_idx_q [hzo_pkg::NUM_GRP];
  logic [hzo_pkg::ADDR_W-1:0]  hm_d;
  logic [hzo_pkg::ADDR_W:0]    h64;
  logic [hzo_pkg::GRP_W-1:0]   grp;
  logic [hzo_pkg::NUM_GRP-1:0] any_d;
  logic [hzo_pkg::GIDX_W-1:0]  idx_d [hzo_pkg::NUM_GRP];

  // Stage 2: leading-one position and shift amount.
  logic                        s2_vld_q;
  logic [hzo_pkg::ADDR_W:0]    s2_w_q;
  logic [hzo_pkg::LVL_W-1:0]   s2_sh_q;
  logic                        s2_nz_q;
  logic                        s2_big_q;
  logic [hzo_pkg::LVL_W-1:0]   msb;
  logic [hzo_pkg::LVL_W-1:0]   sh_d;

  // Stage 3: fine shift; stage 4: coarse shift and mask.
  logic                        s3_vld_q;
  logic [hzo_pkg::ADDR_W:0]    s3_w_q;
  logic [2:0]                  s3_shh_q;
  logic                        s3_nz_q;
  logic                        s3_big_q;
  logic [hzo_pkg::ADDR_W:0]    wide;
  logic                        s4_vld_q;
  hzo_pkg::hzo_word_t          s4_q;

  assign rdy4       = !s4_vld_q || out_ready_i;
  assign rdy3       = !s3_vld_q || rdy4;
  assign rdy2       = !s2_vld_q || rdy3;
  assign rdy1       = !s1_vld_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    hm_d = addr_i & info_i.low_mask;
    h64  = {1'b0, hm_d};
    for (int g = 0; g < hzo_pkg::NUM_GRP; g++) begin
      grp      = h64[g*hzo_pkg::GRP_W +: hzo_pkg::GRP_W];
      any_d[g] = |grp;
      idx_d[g] = '0;
      for (int i = 0; i < hzo_pkg::GRP_W; i++) begin
        if (grp[i]) idx_d[g] = hzo_pkg::GIDX_W'(i);
      end
    end
  end

  always_comb begin
    msb = '0;
    for (int g = 0; g < hzo_pkg::NUM_GRP; g++) begin
      if (s1_any_q[g]) msb = {hzo_pkg::GIDX_W'(g), s1_idx_q[g]};
    end
    // The top bit of (2h+1) sits one above the leading one of h.
    sh_d = info_i.level_count - hzo_pkg::LVL_W'(1) - msb;
  end

  assign wide = s3_w_q << {s3_shh_q, 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (rdy1) s1_vld_q <= in_valid_i;
      if (rdy2) s2_vld_q <= s1_vld_q;
      if (rdy3) s3_vld_q <= s2_vld_q;
      if (rdy4) s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_hm_q  <= hm_d;
      s1_big_q <= |(addr_i & ~info_i.low_mask);
      s1_any_q <= any_d;
      s1_idx_q <= idx_d;
    end
    if (rdy2) begin
      s2_w_q   <= {s1_hm_q, 1'b1};
      s2_sh_q  <= sh_d;
      s2_nz_q  <= |s1_any_q;
      s2_big_q <= s1_big_q;
    end
    if (rdy3) begin
      s3_w_q   <= s2_w_q << s2_sh_q[2:0];
      s3_shh_q <= s2_sh_q[hzo_pkg::LVL_W-1:3];
      s3_nz_q  <= s2_nz_q;
      s3_big_q <= s2_big_q;
    end
    if (rdy4) begin
      s4_q.bits    <= s3_nz_q ? (wide[hzo_pkg::ADDR_W-1:0] & info_i.low_mask) : '0;
      s4_q.too_big <= s3_big_q;
    end
  end

  assign out_valid_o = s4_vld_q;
  assign out_o       = s4_q;

endmodule

>>> rtl/hzo_scatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hzo_scatter
// Output stage: picks each coordinate bit from its level position and holds
// the finished result until it is taken.
// ----------------------------------------------------------------------------
module hzo_scatter #(
  parameter int KEEP_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  hzo_pkg::hzo_word_t          word_i,
  input  hzo_pkg::lvl_t               pos_i    [hzo_pkg::NUM_AXES][KEEP_BITS],
  input  logic                        pos_ok_i [hzo_pkg::NUM_AXES][KEEP_BITS],
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hzo_pkg::COORD_W-1:0] coord_o  [hzo_pkg::NUM_AXES],
  output logic                        too_big_o
);

  logic [hzo_pkg::ADDR_W:0]    bits64;
  logic [hzo_pkg::COORD_W-1:0] coord_d [hzo_pkg::NUM_AXES];
  logic [hzo_pkg::COORD_W-1:0] coord_q [hzo_pkg::NUM_AXES];
  logic                        too_big_q;
  logic                        valid_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    bits64 = {1'b0, word_i.bits};
    for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
      coord_d[a] = '0;
      for (int k = 0; k < KEEP_BITS; k++) begin
        coord_d[a][k] = pos_ok_i[a][k] & bits64[pos_i[a][k]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      coord_q   <= coord_d;
      too_big_q <= word_i.too_big;
    end
  end

  assign out_valid_o = valid_q;
  assign coord_o     = coord_q;
  assign too_big_o   = too_big_q;

endmodule

>>> rtl/hzo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hzo_checker
// Port-level checks of the decoder: result hold under stall, occupancy
// bounds and input hold-off after a configuration write.
// ----------------------------------------------------------------------------
module hzo_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [hzo_pkg::COORD_W-1:0] coord_x_o,
  input logic                        address_too_big_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o
);

  localparam logic [2:0] DEPTH = 3'd5;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] pending_q, pending_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Transactions accepted at the input and not yet delivered.
  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) pending_d = pending_q + 3'd1;
    if (!in_acc && out_acc) pending_d = pending_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(coord_x_o) && $stable(address_too_big_o))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pending_q != 3'd0)
    else $error("result delivered without a pending transaction");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= DEPTH)
    else $error("more transactions in flight than pipeline stages");

  a_cfg_holdoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o)
    else $error("input accepted while the level map is rebuilt");

endmodule

bind hz_order_to_coordinates hzo_checker u_hzo_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .coord_x_o         (coord_x_o),
  .address_too_big_o (address_too_big_o),
  .cfg_valid_i       (cfg_valid_i),
  .cfg_ready_o       (cfg_ready_o)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hierarchical Z-order decoder. It programs the
// five axis exponents, streams addresses under random and forced
// back-pressure, and compares every decoded coordinate set with a local
// model of the level map and the bit scatter.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 9;
  localparam int IDLE_PERCENT    = 18;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_PRINTED     = 50;
  localparam int RANDOM_PHASES   = 20;
  localparam int PHASE_ITEMS     = 100;
  localparam int TABLE_DEPTH     = 63;
  localparam int EXP_IN_RANGE    = 24;
  localparam int EXP_TOP         = (1 << hzo_pkg::EXP_W) - 1;

  typedef enum logic [hzo_pkg::CFG_IDX_W-1:0] {
    REG_BITS_X,
    REG_BITS_Y,
    REG_BITS_Z,
    REG_BITS_U,
    REG_BITS_V
  } axis_reg_e;

  // First register index that maps to no axis.
  localparam logic [hzo_pkg::CFG_IDX_W-1:0] REG_UNMAPPED =
    hzo_pkg::CFG_IDX_W'(hzo_pkg::NUM_AXES);

  typedef struct packed {
    logic [hzo_pkg::COORD_W-1:0] coord_x;
    logic [hzo_pkg::COORD_W-1:0] coord_y;
    logic [hzo_pkg::COORD_W-1:0] coord_z;
    logic [hzo_pkg::COORD_W-1:0] coord_u;
    logic [hzo_pkg::COORD_W-1:0] coord_v;
    logic                        too_big;
  } coord_set_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [hzo_pkg::ADDR_W-1:0]    hz_address_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [hzo_pkg::COORD_W-1:0]   coord_x_o;
  logic [hzo_pkg::COORD_W-1:0]   coord_y_o;
  logic [hzo_pkg::COORD_W-1:0]   coord_z_o;
  logic [hzo_pkg::COORD_W-1:0]   coord_u_o;
  logic [hzo_pkg::COORD_W-1:0]   coord_v_o;
  logic                          address_too_big_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [hzo_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [hzo_pkg::EXP_W-1:0]     cfg_data_i = '0;

  hz_order_to_coordinates dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .hz_address_i     (hz_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .coord_x_o        (coord_x_o),
    .coord_y_o        (coord_y_o),
    .coord_z_o        (coord_z_o),
    .coord_u_o        (coord_u_o),
    .coord_v_o        (coord_v_o),
    .address_too_big_o(address_too_big_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Local copy of the decoder state.
  logic [hzo_pkg::EXP_W-1:0] axis_exp [hzo_pkg::NUM_AXES];
  logic [2:0]                level_axis_map [TABLE_DEPTH];
  int                        level_total;

  coord_set_t pending_coords [$];
  int         mismatch_count = 0;
  int         sent_count;
  int         result_count = 0;
  int         cfg_write_count;
  bit         quiet;
  int         holds_requested;
  int         holds_served = 0;
  int         hold_left = 0;
  int         stall_cycles = 0;

  function automatic void rebuild_level_map();
    int top_exp;
    int n;
    top_exp = 0;
    n = 0;
    for (int j = 0; j < TABLE_DEPTH; j++) level_axis_map[j] = '0;
    for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
      if (int'(axis_exp[a]) > top_exp) top_exp = int'(axis_exp[a]);
    end
    // Finest level first; at each threshold the highest axis index goes first.
    for (int t = 1; t <= top_exp; t++) begin
      for (int a = hzo_pkg::NUM_AXES - 1; a >= 0; a--) begin
        if (int'(axis_exp[a]) >= t && n < TABLE_DEPTH) begin
          level_axis_map[n] = 3'(a);
          n++;
        end
      end
    end
    level_total = n;
  endfunction

  function automatic logic [63:0] level_mask();
    return (level_total >= 64) ? '1 : ((64'd1 << level_total) - 64'd1);
  endfunction

  function automatic coord_set_t decode_hz_address(logic [hzo_pkg::ADDR_W-1:0] addr);
    logic [63:0] h;
    logic [63:0] v;
    logic [63:0] mask;
    logic [63:0] coord [hzo_pkg::NUM_AXES];
    int          cnt [hzo_pkg::NUM_AXES];
    int          ax;
    coord_set_t  r;
    h = {1'b0, addr};
    mask = level_mask();
    for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
      coord[a] = '0;
      cnt[a] = 0;
    end
    r.too_big = (h >> level_total) != 64'd0;
    // Form 2h+1 and slide it up until its leading one sits on bit L.
    v = ((h & mask) << 1) | 64'd1;
    while (v[level_total] == 1'b0) v = v << 1;
    v = v & mask;
    for (int j = 0; j < level_total; j++) begin
      ax = int'(level_axis_map[j]);
      if (v[j] && cnt[ax] < 64) coord[ax][cnt[ax]] = 1'b1;
      cnt[ax]++;
    end
    r.coord_x = coord[0][hzo_pkg::COORD_W-1:0];
    r.coord_y = coord[1][hzo_pkg::COORD_W-1:0];
    r.coord_z = coord[2][hzo_pkg::COORD_W-1:0];
    r.coord_u = coord[3][hzo_pkg::COORD_W-1:0];
    r.coord_v = coord[4][hzo_pkg::COORD_W-1:0];
    return r;
  endfunction

  function automatic logic [hzo_pkg::ADDR_W-1:0] random_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[hzo_pkg::ADDR_W-1:0];
  endfunction

  function automatic logic [hzo_pkg::ADDR_W-1:0] random_address();
    logic [hzo_pkg::ADDR_W-1:0] a;
    case ($urandom_range(0, 9))
      0: a = random_word();
      1: a = hzo_pkg::ADDR_W'(64'd1 << $urandom_range(0, hzo_pkg::ADDR_W - 1));
      2: a = $urandom_range(0, 1) ? '1 : '0;
      3: a = hzo_pkg::ADDR_W'(level_mask()) ^
             hzo_pkg::ADDR_W'(64'd1 << $urandom_range(0, hzo_pkg::ADDR_W - 1));
      default: a = random_word() & hzo_pkg::ADDR_W'(level_mask());
    endcase
    return a;
  endfunction

  function automatic bit sender_idles();
    return !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $time, result_count, field, got, want);
    mismatch_count++;
  endtask

  // All tasks below start and end just after a falling edge.
  task automatic send_address(input logic [hzo_pkg::ADDR_W-1:0] addr);
    while (sender_idles()) begin
      in_valid_i = 1'b0;
      hz_address_i = random_word();
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    hz_address_i = addr;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_coords.push_back(decode_hz_address(addr));
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i = 1'b0;
    while (pending_coords.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_axis_reg(input logic [hzo_pkg::CFG_IDX_W-1:0] index,
                                input logic [hzo_pkg::EXP_W-1:0] value);
    wait_for_results();
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i = value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (int'(index) < hzo_pkg::NUM_AXES) begin
      axis_exp[index] = value;
      rebuild_level_map();
    end
    cfg_write_count++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_exponents(input int ex, input int ey, input int ez,
                               input int eu, input int ev);
    write_axis_reg(REG_BITS_X, hzo_pkg::EXP_W'(ex));
    write_axis_reg(REG_BITS_Y, hzo_pkg::EXP_W'(ey));
    write_axis_reg(REG_BITS_Z, hzo_pkg::EXP_W'(ez));
    write_axis_reg(REG_BITS_U, hzo_pkg::EXP_W'(eu));
    write_axis_reg(REG_BITS_V, hzo_pkg::EXP_W'(ev));
  endtask

  // With no levels every coordinate is zero and any nonzero address overflows.
  task automatic test_no_levels();
    send_address('0);
    send_address(hzo_pkg::ADDR_W'(1));
    send_address('1);
    send_address(hzo_pkg::ADDR_W'(64'd1 << (hzo_pkg::ADDR_W - 1)));
  endtask

  task automatic test_field_extremes();
    logic [hzo_pkg::ADDR_W-1:0] m;
    set_exponents(3, 2, 1, 0, 4);
    m = hzo_pkg::ADDR_W'(level_mask());
    send_address('0);
    send_address(hzo_pkg::ADDR_W'(1));
    send_address(m);
    send_address(m ^ (m >> 1));
    send_address(m + hzo_pkg::ADDR_W'(1));
    send_address('1);
    send_address(m & hzo_pkg::ADDR_W'({(hzo_pkg::ADDR_W / 2 + 1){2'b01}}));
    send_address(m & hzo_pkg::ADDR_W'({(hzo_pkg::ADDR_W / 2 + 1){2'b10}}));
  endtask

  // Exponents summing past the table depth, and one exponent above 24.
  task automatic test_level_overflow();
    set_exponents(EXP_IN_RANGE, EXP_IN_RANGE, EXP_IN_RANGE, EXP_IN_RANGE, EXP_IN_RANGE);
    send_address('0);
    send_address('1);
    send_address(hzo_pkg::ADDR_W'(64'd1 << (hzo_pkg::ADDR_W - 1)));
    send_address(random_word());
    set_exponents(EXP_TOP, 0, 0, 0, 0);
    send_address('1);
    send_address(hzo_pkg::ADDR_W'(level_mask()));
    send_address(hzo_pkg::ADDR_W'(64'd1 << (EXP_TOP - 1)));
    send_address(random_word());
  endtask

  // Writes to indexes past the last axis must leave the level map alone.
  task automatic test_unmapped_index();
    set_exponents(2, 5, 0, 7, 1);
    for (int idx = int'(REG_UNMAPPED); idx < (1 << hzo_pkg::CFG_IDX_W); idx++)
      write_axis_reg(hzo_pkg::CFG_IDX_W'(idx), hzo_pkg::EXP_W'(EXP_TOP));
    send_address(hzo_pkg::ADDR_W'(level_mask()));
    send_address(random_word());
    send_address(hzo_pkg::ADDR_W'(5));
  endtask

  task automatic test_backpressure();
    set_exponents(6, 9, 3, 12, 4);
    holds_requested++;
    repeat (40) send_address(random_address());
    wait_for_results();
    repeat (40) send_address(random_address());
  endtask

  task automatic test_random_configs();
    int e [hzo_pkg::NUM_AXES];
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int a = 0; a < hzo_pkg::NUM_AXES; a++) begin
        case ($urandom_range(0, 7))
          0: e[a] = 0;
          1: e[a] = EXP_IN_RANGE;
          2: e[a] = $urandom_range(EXP_IN_RANGE + 1, EXP_TOP);
          3: e[a] = $urandom_range(0, EXP_IN_RANGE);
          default: e[a] = $urandom_range(0, 8);
        endcase
      end
      set_exponents(e[0], e[1], e[2], e[3], e[4]);
      quiet = (p == 3);
      repeat (PHASE_ITEMS) send_address(random_address());
      quiet = 1'b0;
    end
  endtask

  // Receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      out_stall_i <= 1'b1;
      holds_served <= holds_served + 1;
      hold_left <= HOLD_OFF_CYCLES;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk_i) begin
    coord_set_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_coords.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = pending_coords.pop_front();
        if (coord_x_o !== want.coord_x)
          report_mismatch("coord_x", 32'(coord_x_o), 32'(want.coord_x));
        if (coord_y_o !== want.coord_y)
          report_mismatch("coord_y", 32'(coord_y_o), 32'(want.coord_y));
        if (coord_z_o !== want.coord_z)
          report_mismatch("coord_z", 32'(coord_z_o), 32'(want.coord_z));
        if (coord_u_o !== want.coord_u)
          report_mismatch("coord_u", 32'(coord_u_o), 32'(want.coord_u));
        if (coord_v_o !== want.coord_v)
          report_mismatch("coord_v", 32'(coord_v_o), 32'(want.coord_v));
        if (address_too_big_o !== want.too_big)
          report_mismatch("address_too_big", 32'(address_too_big_o), 32'(want.too_big));
      end
      result_count++;
    end
  end

  // Ends the run when no transaction of any kind completes for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without a transaction", stall_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int a = 0; a < hzo_pkg::NUM_AXES; a++) axis_exp[a] = '0;
    rebuild_level_map();
    sent_count = 0;
    cfg_write_count = 0;
    quiet = 1'b0;
    holds_requested = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_no_levels();
    test_field_extremes();
    test_level_overflow();
    test_unmapped_index();
    test_backpressure();
    test_random_configs();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Decoded %0d addresses into %0d results across %0d register writes,",
             sent_count, result_count, cfg_write_count);
    $display("including empty, saturated and out-of-range level maps and long hold-offs.");
    if (mismatch_count == 0 && pending_coords.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_coords.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> hz_order_to_coordinates.f
rtl/hzo_pkg.sv
rtl/hzo_level_map.sv
rtl/hzo_align.sv
rtl/hzo_scatter.sv
rtl/hz_order_to_coordinates.sv
rtl/hzo_checker.sv
bench/testbench.sv
